// ===== rtl/grm_pkg.sv =====
// ----------------------------------------------------------------------------
// grm_pkg
// Shared types, constants and helpers for the greedy rectangle merge block.
// ----------------------------------------------------------------------------
package grm_pkg;

  // plane edge length in cells, along u and along v
  localparam int unsigned PLANE_SIZE = 32;
  // index of one row or one bit inside a row
  localparam int unsigned IDX_W      = $clog2(PLANE_SIZE);
  // counter that can also hold PLANE_SIZE itself
  localparam int unsigned CNT_W      = IDX_W + 1;

  typedef logic [PLANE_SIZE-1:0] row_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // op codes; code 3 has no meaning, leaves the plane unchanged and only gets a response
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } op_e;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_FIND   = 6'b000010,
    ST_WIDEN  = 6'b000100,
    ST_HEIGHT = 6'b001000,
    ST_ERASE  = 6'b010000,
    ST_RESP   = 6'b100000
  } state_e;

  // index of the single set bit of a one-hot word (zero word gives zero)
  function automatic idx_t onehot_index(input row_t oh);
    idx_t idx;
    idx = '0;
    for (int unsigned i = 0; i < PLANE_SIZE; i++) begin
      if (oh[i]) begin
        idx = idx | idx_t'(i);
      end
    end
    return idx;
  endfunction

  // isolate the lowest set bit
  function automatic row_t lowest_bit(input row_t x);
    return x & (~x + row_t'(1));
  endfunction

endpackage

// ===== rtl/greedy_rectangle_merge.sv =====
// ----------------------------------------------------------------------------
// greedy_rectangle_merge
// Occupancy plane covered by greedy merged rectangles, one per pop.
// ----------------------------------------------------------------------------
// The block keeps a PLANE_SIZE x PLANE_SIZE occupancy bitmap as one row of
// v bits per u coordinate, and answers every input transaction with exactly
// one output transaction. Clear and insert update the plane on acceptance,
// then wait in the response state for the output handoff. A pop runs a small
// sequencer around one row read port: it scans rows from u = 0 until it
// meets a nonempty one, picks the least v there, walks along u while the
// start bit stays set and ANDs the rows together, derives the height and the
// clear mask from the AND in the height state, then erases the rectangle one
// row per cycle. in_stall_o stays high from acceptance until the result has
// been placed in the output register; the output register lets the next
// transaction be accepted while a result still waits to be taken.
module greedy_rectangle_merge (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               op_i,
  input  logic [4:0]               cell_u_i,
  input  logic [4:0]               cell_v_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o,
  output logic [grm_pkg::IDX_W-1:0] rect_u_o,
  output logic [grm_pkg::IDX_W-1:0] rect_v_o,
  output logic [grm_pkg::CNT_W-1:0] rect_u_end_o,
  output logic [grm_pkg::CNT_W-1:0] rect_v_end_o,
  output logic                     plane_empty_o
);
  import grm_pkg::*;

  // occupancy: occ_q[u] bit v
  row_t   occ_q [PLANE_SIZE];
  row_t   occ_d [PLANE_SIZE];
  logic [PLANE_SIZE-1:0] row_nz;

  state_e state_q, state_d;
  cnt_t   cnt_q, cnt_d;      // shared row counter for scan, widen and erase
  idx_t   su_q, su_d;        // start u
  idx_t   sv_q, sv_d;        // start v
  cnt_t   uend_q, uend_d;    // exclusive end u
  cnt_t   vend_q, vend_d;    // exclusive end v
  row_t   acc_q, acc_d;      // AND of the rows in the rectangle's width
  row_t   mask_q, mask_d;    // v bits to clear
  logic   found_q, found_d;

  logic   out_valid_q, out_valid_d;
  logic   o_found_q, o_found_d;
  idx_t   o_u_q, o_u_d;
  idx_t   o_v_q, o_v_d;
  cnt_t   o_ue_q, o_ue_d;
  cnt_t   o_ve_q, o_ve_d;
  logic   o_empty_q, o_empty_d;

  logic   in_acc;
  logic   out_free;
  row_t   row_rd;            // the one row read this cycle
  logic   cnt_end;           // counter reached the plane edge
  row_t   shifted;
  row_t   gap;               // lowest zero of the shifted AND, one-hot
  idx_t   gap_idx;

  always_comb begin
    for (int unsigned i = 0; i < PLANE_SIZE; i++) begin
      row_nz[i] = |occ_q[i];
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign row_rd     = occ_q[cnt_q[IDX_W-1:0]];
  assign cnt_end    = (cnt_q == cnt_t'(PLANE_SIZE));

  // height unit: run of ones in the AND starting at the start v
  assign shifted = acc_q >> sv_q;
  assign gap     = lowest_bit(~shifted);
  assign gap_idx = onehot_index(gap);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    su_d      = su_q;
    sv_d      = sv_q;
    uend_d    = uend_q;
    vend_d    = vend_q;
    acc_d     = acc_q;
    mask_d    = mask_q;
    found_d   = found_q;
    occ_d     = occ_q;

    out_valid_d = out_valid_q && out_stall_i;
    o_found_d   = o_found_q;
    o_u_d       = o_u_q;
    o_v_d       = o_v_q;
    o_ue_d      = o_ue_q;
    o_ve_d      = o_ve_q;
    o_empty_d   = o_empty_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          found_d = 1'b0;
          cnt_d   = '0;
          case (op_i)
            OP_CLEAR: begin
              for (int unsigned i = 0; i < PLANE_SIZE; i++) begin
                occ_d[i] = '0;
              end
              state_d = ST_RESP;
            end
            OP_INSERT: begin
              if (({1'b0, cell_u_i} < 6'(PLANE_SIZE)) &&
                  ({1'b0, cell_v_i} < 6'(PLANE_SIZE))) begin
                occ_d[cell_u_i[IDX_W-1:0]][cell_v_i[IDX_W-1:0]] = 1'b1;
              end
              state_d = ST_RESP;
            end
            OP_POP: begin
              state_d = ST_FIND;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_FIND: begin
        if (cnt_end) begin
          state_d = ST_RESP;
        end else if (row_rd != '0) begin
          su_d    = cnt_q[IDX_W-1:0];
          sv_d    = onehot_index(lowest_bit(row_rd));
          acc_d   = row_rd;
          cnt_d   = cnt_q + cnt_t'(1);
          state_d = ST_WIDEN;
        end else begin
          cnt_d = cnt_q + cnt_t'(1);
        end
      end
      ST_WIDEN: begin
        if (cnt_end || !row_rd[sv_q]) begin
          uend_d  = cnt_q;
          state_d = ST_HEIGHT;
        end else begin
          acc_d = acc_q & row_rd;
          cnt_d = cnt_q + cnt_t'(1);
        end
      end
      ST_HEIGHT: begin
        mask_d  = (gap - row_t'(1)) << sv_q;
        vend_d  = (gap == '0) ? cnt_t'(PLANE_SIZE)
                              : cnt_t'(sv_q) + cnt_t'(gap_idx);
        cnt_d   = cnt_t'(su_q);
        found_d = 1'b1;
        state_d = ST_ERASE;
      end
      ST_ERASE: begin
        occ_d[cnt_q[IDX_W-1:0]] = row_rd & ~mask_q;
        cnt_d = cnt_q + cnt_t'(1);
        if ((cnt_q + cnt_t'(1)) == uend_q) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        // wait for the output register, then hand the result over
        if (out_free) begin
          out_valid_d = 1'b1;
          o_found_d   = found_q;
          o_u_d       = found_q ? su_q   : '0;
          o_v_d       = found_q ? sv_q   : '0;
          o_ue_d      = found_q ? uend_q : '0;
          o_ve_d      = found_q ? vend_q : '0;
          o_empty_d   = ~|row_nz;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int unsigned i = 0; i < PLANE_SIZE; i++) begin
        occ_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      occ_q       <= occ_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    su_q      <= su_d;
    sv_q      <= sv_d;
    uend_q    <= uend_d;
    vend_q    <= vend_d;
    acc_q     <= acc_d;
    mask_q    <= mask_d;
    found_q   <= found_d;
    o_found_q <= o_found_d;
    o_u_q     <= o_u_d;
    o_v_q     <= o_v_d;
    o_ue_q    <= o_ue_d;
    o_ve_q    <= o_ve_d;
    o_empty_q <= o_empty_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = o_found_q;
  assign rect_u_o      = o_u_q;
  assign rect_v_o      = o_v_q;
  assign rect_u_end_o  = o_ue_q;
  assign rect_v_end_o  = o_ve_q;
  assign plane_empty_o = o_empty_q;

endmodule
